### src/baace_pkg.sv
// Package for the block average ANSI color encoder.
// Holds shared types, byte codes and the front-to-back request struct.
package baace_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 2'd3;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // One request from the front part: optional block color, optional row end.
    typedef struct packed {
        logic        has_block;
        logic [23:0] color;
        logic        send_color;
        logic        row_end;
        logic        row_reset;
    } baace_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLOR_HEAD,
        ST_RED,
        ST_SEMI1,
        ST_GREEN,
        ST_SEMI2,
        ST_BLUE,
        ST_COLOR_M,
        ST_BLACK,
        ST_SPACE,
        ST_ROW_RESET,
        ST_NEWLINE
    } baace_state_t;

    typedef enum logic [2:0] {
        F_IN,
        F_READ,
        F_DIV_R,
        F_DIV_G,
        F_DIV_B,
        F_SEND
    } baace_fstate_t;

    function automatic logic [7:0] head_byte(input logic [2:0] i);
        logic [7:0] b;
        unique case (i)
            3'd0: b = CH_ESC;
            3'd1: b = CH_LBR;
            3'd2: b = CH_FOUR;
            3'd3: b = CH_EIGHT;
            3'd4: b = CH_SEMI;
            3'd5: b = CH_TWO;
            3'd6: b = CH_SEMI;
            default: b = CH_ESC;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reset_byte(input logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0: b = CH_ESC;
            2'd1: b = CH_LBR;
            2'd2: b = CH_ZERO;
            default: b = CH_M;
        endcase
        return b;
    endfunction

endpackage

### src/baace_if.sv
// Valid/ready channel interfaces for pixels, bytes and configuration writes.
// Depends on nothing.
interface baace_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface baace_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    modport source (output valid, out_byte, run_last, input ready);
    modport sink (input valid, out_byte, run_last, output ready);
endinterface

interface baace_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/block_average_ansi_color_encoder_top.sv
// Top level of the block average ANSI color encoder.
// Depends on baace_pkg, the channel interfaces, baace_front and baace_back.
// Pixels enter in raster order; a new pixel is taken only after the front part has
// handled the last one and while the one-entry request register ahead of the byte
// sequencer is empty. A pixel that only ends a block row holds the pixel channel
// while its row-end request is posted. A pixel that closes a block holds it while
// the front part reads the line store, runs three serial divisions and posts the
// request. The pixel channel then stays held until the byte sequencer, which sends
// one byte per cycle while the byte channel is ready, has taken that request.
// Configuration writes are always accepted and restart the frame.
module block_average_ansi_color_encoder_top #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BLOCK = 64
) (
    input logic         clk,
    input logic         rst_n,
    baace_pixel_if.sink pixel,
    baace_byte_if.source bytes,
    baace_cfg_if.sink   cfg
);
    logic                  req_valid, req_ready;
    baace_pkg::baace_req_t req;

    assign cfg.ready = 1'b1;

    baace_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_BLOCK(MAX_BLOCK)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pixel.valid),
        .pix_ready(pixel.ready),
        .red      (pixel.red),
        .green    (pixel.green),
        .blue     (pixel.blue),
        .cfg_write(cfg.valid),
        .cfg_index(cfg.index),
        .cfg_data (cfg.data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req)
    );

    baace_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .byte_valid(bytes.valid),
        .byte_ready(bytes.ready),
        .out_byte  (bytes.out_byte),
        .run_last  (bytes.run_last)
    );
endmodule

### src/baace_div.sv
// Sequential restoring divider for block sums by the block area.
// Depends on nothing but its ports.
module baace_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

### src/baace_front.sv
// Front part: raster position, line store of block sums, block averaging.
// Depends on baace_pkg and baace_div; issues requests to the back part.
module baace_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BLOCK = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    output logic                  req_valid,
    input  logic                  req_ready,
    output baace_pkg::baace_req_t req
);
    localparam int POS_W = $clog2(MAX_WIDTH + 1);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int BLK_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = 8 + 2 * BLK_W;
    localparam int AREA_W = 2 * BLK_W;

    logic [12:0] iw_reg, ih_reg;
    logic [6:0]  bw_reg, bh_reg;
    logic [POS_W-1:0] w, h;
    logic [BLK_W-1:0] bw, bh;

    logic [POS_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [BLK_W-1:0] coff_reg, coff_next, roff_reg, roff_next;
    logic [POS_W-1:0] bcol_reg, bcol_next, brow_reg, brow_next;
    logic [23:0]      prev_reg, prev_next;

    logic [3*SUM_W-1:0] mem [MAX_WIDTH];
    logic [3*SUM_W-1:0] rd_reg;

    baace_pkg::baace_fstate_t fs_reg, fs_next;

    logic [7:0] pr_reg, pg_reg, pb_reg;
    logic       first_reg, last_blk_reg, in_blk_reg, row_end_reg;
    logic [COL_W-1:0] addr_reg;
    logic [3*SUM_W-1:0] sum_new;
    logic [SUM_W-1:0] s_r, s_g, s_b;
    logic [7:0] avg_r_reg, avg_g_reg;
    baace_pkg::baace_req_t req_reg, req_next;
    logic req_valid_reg, req_valid_next;

    logic div_start, div_done;
    logic [SUM_W-1:0] div_num, div_q;
    logic [AREA_W-1:0] area;

    function automatic logic [POS_W-1:0] clamp_img(input logic [12:0] v);
        logic [POS_W-1:0] r;
        if (v == 13'd0)
            r = POS_W'(1);
        else if (32'(v) > MAX_WIDTH)
            r = POS_W'(MAX_WIDTH);
        else
            r = POS_W'(v);
        return r;
    endfunction

    function automatic logic [BLK_W-1:0] clamp_blk(input logic [6:0] v);
        logic [BLK_W-1:0] r;
        if (v == 7'd0)
            r = BLK_W'(1);
        else if (32'(v) > MAX_BLOCK)
            r = BLK_W'(MAX_BLOCK);
        else
            r = BLK_W'(v);
        return r;
    endfunction

    assign w = clamp_img(iw_reg);
    assign h = clamp_img(ih_reg);
    assign bw = clamp_blk(bw_reg);
    assign bh = clamp_blk(bh_reg);
    assign area = AREA_W'(bw) * AREA_W'(bh);

    // Configuration registers; a write also restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= 13'd1;
            ih_reg <= 13'd1;
            bw_reg <= 7'd1;
            bh_reg <= 7'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                baace_pkg::REG_IMAGE_WIDTH:  iw_reg <= cfg_data;
                baace_pkg::REG_IMAGE_HEIGHT: ih_reg <= cfg_data;
                baace_pkg::REG_BLOCK_WIDTH:  bw_reg <= cfg_data[6:0];
                default:                     bh_reg <= cfg_data[6:0];
            endcase
        end
    end

    logic accept;
    logic blk_ok_x, blk_ok_y, blk_last, row_last;

    assign pix_ready = (fs_reg == baace_pkg::F_IN) && !req_valid_reg;
    assign accept = pix_valid && pix_ready;
    // Block fits whole when its last column and row lie inside the image.
    assign blk_ok_x = ((POS_W+1)'(col_reg) + (POS_W+1)'(bw) - (POS_W+1)'(coff_reg))
                      <= (POS_W+1)'(w);
    assign blk_ok_y = ((POS_W+1)'(row_reg) + (POS_W+1)'(bh) - (POS_W+1)'(roff_reg))
                      <= (POS_W+1)'(h);
    assign blk_last = (coff_reg == bw - 1'b1) && (roff_reg == bh - 1'b1);
    assign row_last = (roff_reg == bh - 1'b1) && (col_reg == w - 1'b1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        coff_next = coff_reg;
        roff_next = roff_reg;
        bcol_next = bcol_reg;
        brow_next = brow_reg;
        if (accept)
        begin
            if (col_reg == w - 1'b1)
            begin
                col_next = '0;
                coff_next = '0;
                bcol_next = '0;
                if (row_reg == h - 1'b1)
                begin
                    row_next = '0;
                    roff_next = '0;
                    brow_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    if (roff_reg == bh - 1'b1)
                    begin
                        roff_next = '0;
                        brow_next = brow_reg + 1'b1;
                    end
                    else
                        roff_next = roff_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (coff_reg == bw - 1'b1)
                begin
                    coff_next = '0;
                    bcol_next = bcol_reg + 1'b1;
                end
                else
                    coff_next = coff_reg + 1'b1;
            end
        end
    end

    assign s_r = rd_reg[3*SUM_W-1:2*SUM_W];
    assign s_g = rd_reg[2*SUM_W-1:SUM_W];
    assign s_b = rd_reg[SUM_W-1:0];
    assign sum_new = first_reg ? {SUM_W'(pr_reg), SUM_W'(pg_reg), SUM_W'(pb_reg)}
                   : {s_r + SUM_W'(pr_reg), s_g + SUM_W'(pg_reg), s_b + SUM_W'(pb_reg)};

    always_comb
    begin
        fs_next = fs_reg;
        div_start = 1'b0;
        div_num = sum_new[3*SUM_W-1:2*SUM_W];
        req_next = req_reg;
        req_valid_next = req_valid_reg;
        prev_next = prev_reg;
        if (req_valid_reg && req_ready)
            req_valid_next = 1'b0;
        unique case (fs_reg)
            baace_pkg::F_IN:
            begin
                if (accept)
                    fs_next = baace_pkg::F_READ;
            end
            baace_pkg::F_READ:
            begin
                if (in_blk_reg && last_blk_reg)
                begin
                    div_start = 1'b1;
                    fs_next = baace_pkg::F_DIV_R;
                end
                else if (row_end_reg)
                begin
                    req_next.has_block = 1'b0;
                    req_next.send_color = 1'b0;
                    req_next.color = '0;
                    req_next.row_end = 1'b1;
                    req_next.row_reset = (prev_reg != 24'd0);
                    prev_next = '0;
                    fs_next = baace_pkg::F_SEND;
                end
                else
                    fs_next = baace_pkg::F_IN;
            end
            baace_pkg::F_DIV_R:
            begin
                div_num = sum_new[2*SUM_W-1:SUM_W];
                if (div_done)
                begin
                    div_start = 1'b1;
                    fs_next = baace_pkg::F_DIV_G;
                end
            end
            baace_pkg::F_DIV_G:
            begin
                div_num = sum_new[SUM_W-1:0];
                if (div_done)
                begin
                    div_start = 1'b1;
                    fs_next = baace_pkg::F_DIV_B;
                end
            end
            baace_pkg::F_DIV_B:
            begin
                if (div_done)
                begin
                    req_next.has_block = 1'b1;
                    req_next.color = {avg_r_reg, avg_g_reg, div_q[7:0]};
                    req_next.send_color = ({avg_r_reg, avg_g_reg, div_q[7:0]} != prev_reg);
                    req_next.row_end = row_end_reg;
                    req_next.row_reset = row_end_reg
                                         && ({avg_r_reg, avg_g_reg, div_q[7:0]} != 24'd0);
                    prev_next = row_end_reg ? 24'd0 : {avg_r_reg, avg_g_reg, div_q[7:0]};
                    fs_next = baace_pkg::F_SEND;
                end
            end
            default:
            begin
                if (!req_valid_reg || req_ready)
                begin
                    req_valid_next = 1'b1;
                    fs_next = baace_pkg::F_IN;
                end
            end
        endcase
        if (cfg_write)
            prev_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= baace_pkg::F_IN;
            col_reg <= '0;
            row_reg <= '0;
            coff_reg <= '0;
            roff_reg <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
            prev_reg <= '0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            fs_reg <= fs_next;
            prev_reg <= prev_next;
            req_valid_reg <= req_valid_next;
            if (cfg_write)
            begin
                col_reg <= '0;
                row_reg <= '0;
                coff_reg <= '0;
                roff_reg <= '0;
                bcol_reg <= '0;
                brow_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                coff_reg <= coff_next;
                roff_reg <= roff_next;
                bcol_reg <= bcol_next;
                brow_reg <= brow_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (accept)
        begin
            pr_reg <= red;
            pg_reg <= green;
            pb_reg <= blue;
            first_reg <= (coff_reg == '0) && (roff_reg == '0);
            last_blk_reg <= blk_last;
            in_blk_reg <= blk_ok_x && blk_ok_y;
            row_end_reg <= row_last && blk_ok_y;
            addr_reg <= COL_W'(bcol_reg);
            rd_reg <= mem[COL_W'(bcol_reg)];
        end
        if (fs_reg == baace_pkg::F_READ && in_blk_reg)
            mem[addr_reg] <= sum_new;
        if (fs_reg == baace_pkg::F_DIV_R && div_done)
            avg_r_reg <= div_q[7:0];
        if (fs_reg == baace_pkg::F_DIV_G && div_done)
            avg_g_reg <= div_q[7:0];
    end

    baace_div #(
        .NUM_W(SUM_W),
        .DEN_W(AREA_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (area),
        .done (div_done),
        .quot (div_q)
    );

    assign req_valid = req_valid_reg;
    assign req = req_reg;
endmodule

### src/baace_back.sv
// Back part: turns block requests into the byte stream, one byte per cycle while the byte channel is ready.
// Depends on baace_pkg; takes requests from the front part's request register, drives the byte channel.
module baace_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  baace_pkg::baace_req_t req,
    output logic                  byte_valid,
    input  logic                  byte_ready,
    output logic [7:0]            out_byte,
    output logic                  run_last
);
    baace_pkg::baace_state_t st_reg, st_next;
    baace_pkg::baace_req_t   cur_reg, cur_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] ob_reg, ob_next;
    logic       last_reg, last_next, v_reg, v_next;
    logic [7:0] comp;
    logic [7:0] rem99;
    logic [15:0] prod;
    logic [1:0] ndig;
    logic [7:0] dig_b;
    logic [3:0] hund, tens, ones;
    logic       go;

    always_comb
    begin
        unique case (st_reg)
            baace_pkg::ST_RED:   comp = cur_reg.color[23:16];
            baace_pkg::ST_GREEN: comp = cur_reg.color[15:8];
            default:             comp = cur_reg.color[7:0];
        endcase
        hund = (comp >= 8'd200) ? 4'd2 : (comp >= 8'd100) ? 4'd1 : 4'd0;
        rem99 = comp - 8'(hund) * 8'd100;
        // Tens digit by reciprocal multiplication, exact for values below 100.
        prod = 16'(rem99) * 16'd205;
        tens = prod[14:11];
        ones = 4'(rem99 - 8'(tens) * 8'd10);
        ndig = (comp >= 8'd100) ? 2'd3 : (comp >= 8'd10) ? 2'd2 : 2'd1;
        unique case (idx_reg[1:0] + (2'd3 - ndig))
            2'd0:    dig_b = baace_pkg::CH_ZERO + 8'(hund);
            2'd1:    dig_b = baace_pkg::CH_ZERO + 8'(tens);
            default: dig_b = baace_pkg::CH_ZERO + 8'(ones);
        endcase
    end

    assign go = !v_reg || byte_ready;

    always_comb
    begin
        st_next = st_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        ob_next = ob_reg;
        last_next = last_reg;
        v_next = v_reg && !byte_ready;
        req_ready = 1'b0;
        if (go)
        begin
            v_next = 1'b0;
            unique case (st_reg)
                baace_pkg::ST_IDLE:
                begin
                    req_ready = 1'b1;
                    if (req_valid)
                    begin
                        cur_next = req;
                        idx_next = '0;
                        if (req.has_block && req.send_color)
                            st_next = (req.color == 24'd0) ? baace_pkg::ST_BLACK
                                                           : baace_pkg::ST_COLOR_HEAD;
                        else if (req.has_block)
                            st_next = baace_pkg::ST_SPACE;
                        else if (req.row_reset)
                            st_next = baace_pkg::ST_ROW_RESET;
                        else
                            st_next = baace_pkg::ST_NEWLINE;
                    end
                end
                baace_pkg::ST_COLOR_HEAD:
                begin
                    ob_next = baace_pkg::head_byte(idx_reg);
                    last_next = 1'b0;
                    v_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd6)
                    begin
                        idx_next = '0;
                        st_next = baace_pkg::ST_RED;
                    end
                end
                baace_pkg::ST_RED, baace_pkg::ST_GREEN, baace_pkg::ST_BLUE:
                begin
                    ob_next = dig_b;
                    last_next = 1'b0;
                    v_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg[1:0] == 2'(ndig - 2'd1))
                    begin
                        idx_next = '0;
                        unique case (st_reg)
                            baace_pkg::ST_RED:   st_next = baace_pkg::ST_SEMI1;
                            baace_pkg::ST_GREEN: st_next = baace_pkg::ST_SEMI2;
                            default:             st_next = baace_pkg::ST_COLOR_M;
                        endcase
                    end
                end
                baace_pkg::ST_SEMI1, baace_pkg::ST_SEMI2:
                begin
                    ob_next = baace_pkg::CH_SEMI;
                    last_next = 1'b0;
                    v_next = 1'b1;
                    st_next = (st_reg == baace_pkg::ST_SEMI1) ? baace_pkg::ST_GREEN
                                                              : baace_pkg::ST_BLUE;
                end
                baace_pkg::ST_COLOR_M:
                begin
                    ob_next = baace_pkg::CH_M;
                    last_next = 1'b0;
                    v_next = 1'b1;
                    st_next = baace_pkg::ST_SPACE;
                end
                baace_pkg::ST_BLACK, baace_pkg::ST_ROW_RESET:
                begin
                    ob_next = baace_pkg::reset_byte(idx_reg[1:0]);
                    last_next = 1'b0;
                    v_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd3)
                    begin
                        idx_next = '0;
                        st_next = (st_reg == baace_pkg::ST_BLACK) ? baace_pkg::ST_SPACE
                                                                  : baace_pkg::ST_NEWLINE;
                    end
                end
                baace_pkg::ST_SPACE:
                begin
                    ob_next = baace_pkg::CH_SPACE;
                    last_next = !cur_reg.row_end;
                    v_next = 1'b1;
                    if (!cur_reg.row_end)
                        st_next = baace_pkg::ST_IDLE;
                    else if (cur_reg.row_reset)
                        st_next = baace_pkg::ST_ROW_RESET;
                    else
                        st_next = baace_pkg::ST_NEWLINE;
                end
                default:
                begin
                    ob_next = baace_pkg::CH_NL;
                    last_next = 1'b1;
                    v_next = 1'b1;
                    st_next = baace_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= baace_pkg::ST_IDLE;
            v_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            v_reg <= v_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ob_reg <= ob_next;
        last_reg <= last_next;
    end

    assign byte_valid = v_reg;
    assign out_byte = ob_reg;
    assign run_last = last_reg;
endmodule

### src/baace_checker.sv
// Port-level checker for the block average ANSI color encoder.
// Depends on baace_pkg and the top level's ports; attached by the bind at the end.
module baace_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       bvalid,
    input logic       bready,
    input logic [7:0] ob,
    input logic       last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid && !bready |=> bvalid && $stable(ob))
        else $error("byte request changed while stalled");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid && last |-> ob == baace_pkg::CH_SPACE || ob == baace_pkg::CH_NL)
        else $error("last byte is neither space nor newline");
    a_esc_next: assert property (@(posedge clk) disable iff (!rst_n)
        bvalid && bready && ob == baace_pkg::CH_ESC |-> !last)
        else $error("escape marked as last byte");
endmodule

bind block_average_ansi_color_encoder_top baace_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .bvalid(bytes.valid),
    .bready(bytes.ready),
    .ob    (bytes.out_byte),
    .last  (bytes.run_last)
);
